// ===== hdl/ddarc_pkg.sv =====
package ddarc_pkg;

	localparam int MAP_COLUMNS_DEF = 64;
	localparam int MAP_ROWS_DEF    = 64;
	localparam int TEX_COLUMNS_DEF = 64;

	localparam int DIST_W = 18;
	localparam logic [DIST_W-1:0] DIST_MAX = '1;

	localparam logic [1:0] KIND_OPEN = 2'd0;
	localparam logic [1:0] KIND_WALL = 2'd1;
	localparam logic [1:0] KIND_DOOR = 2'd2;

	localparam logic OP_WRITE = 1'b0;
	localparam logic OP_CAST  = 1'b1;

	localparam logic [5:0] MAX_CELLS_RESET = 6'd16;

endpackage

// ===== hdl/dda_grid_ray_caster_core.sv =====
// Channel   | Handshake                | Payload
// ----------+--------------------------+------------------------------------------
// command   | start, busy              | op, cell_x, cell_y, tile_kind,
//           |                          | door_passable, pos_x, pos_y, dir_cos, dir_sin
// result    | done (one-cycle strobe)  | hit_distance, hit_side, door_hit,
//           |                          | limit_reached, tex_column
// config    | cfg_we                   | cfg_data (max_ray_cells)
//
// A map write returns no result; busy stays low.
// A cast keeps busy high through the two step-length divisions (one radix-2
// restoring divider, shared by both axes), the side distances, each grid step
// (select, map read, test), the closing limit test and the texture multiply
// and rounding.
// done rises in the first cycle with busy low, so the next transfer may come then.
// Reset clears the sequencer and sets max_ray_cells to 16; the map is not cleared.
// The receiver cannot stall: done is high for exactly one cycle per cast.
module dda_grid_ray_caster_core #(
	parameter int MAP_COLUMNS = ddarc_pkg::MAP_COLUMNS_DEF,
	parameter int MAP_ROWS    = ddarc_pkg::MAP_ROWS_DEF,
	parameter int TEX_COLUMNS = ddarc_pkg::TEX_COLUMNS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic               op,
	input  logic [5:0]         cell_x,
	input  logic [5:0]         cell_y,
	input  logic [1:0]         tile_kind,
	input  logic               door_passable,
	input  logic [15:0]        pos_x,
	input  logic [15:0]        pos_y,
	input  logic signed [15:0] dir_cos,
	input  logic signed [15:0] dir_sin,
	input  logic               cfg_we,
	input  logic [5:0]         cfg_data,
	output logic               done,
	output logic [17:0]        hit_distance,
	output logic               hit_side,
	output logic               door_hit,
	output logic               limit_reached,
	output logic [5:0]         tex_column
);

	localparam int CXW   = $clog2(MAP_COLUMNS);
	localparam int CYW   = $clog2(MAP_ROWS);
	localparam int DEPTH = MAP_COLUMNS * MAP_ROWS;
	localparam int AW    = $clog2(DEPTH);
	localparam int TW    = $clog2(TEX_COLUMNS) + 1;
	localparam int MW    = 12; // signed map coordinate, covers -1 .. 256 with margin

	localparam logic [3:0] ST_IDLE  = 4'd0;
	localparam logic [3:0] ST_DIVX  = 4'd1;
	localparam logic [3:0] ST_DIVY  = 4'd2;
	localparam logic [3:0] ST_SIDEX = 4'd3;
	localparam logic [3:0] ST_SIDEY = 4'd4;
	localparam logic [3:0] ST_TEST  = 4'd5;
	localparam logic [3:0] ST_READ  = 4'd6;
	localparam logic [3:0] ST_CHECK = 4'd7;
	localparam logic [3:0] ST_TEX1  = 4'd8;
	localparam logic [3:0] ST_TEX2  = 4'd9;
	localparam logic [3:0] ST_TEX3  = 4'd10;
	localparam logic [3:0] ST_SIDEW = 4'd11;

	// Map storage: kind and door bit per cell, one write and one read port.
	logic [2:0] map_mem [DEPTH];
	logic [2:0] map_rd_q;

	logic [3:0]  state_q;
	logic [5:0]  max_cells_q;
	logic [15:0] px_q, py_q;
	logic signed [15:0] dc_q, ds_q;
	logic [17:0] dx_q, dy_q, sidex_q, sidey_q, dist_q;
	logic signed [MW-1:0] mx_q, my_q;
	logic        side_q, hit_q, door_q;
	logic        oob_q;
	logic [AW-1:0] rd_addr_q;

	// Shared restoring divider: 2^26 / mag, one quotient bit per cycle.
	logic [16:0] div_rem_q;
	logic [26:0] div_quo_q;
	logic [16:0] div_mag_q;
	logic [4:0]  div_cnt_q;
	logic [17:0] div_trial;
	logic [16:0] div_sub;
	logic        div_qbit;
	logic [26:0] div_quo_nxt;
	logic [17:0] div_res;

	// Shared multiplier, registered output.
	logic [17:0] mul_a;
	logic signed [17:0] mul_b;
	logic signed [36:0] mul_q;
	logic signed [42:0] coord_q;
	logic [TW+25:0] texp_q;

	logic [16:0] mag_x, mag_y;
	logic wr_en;

	always_comb begin
		mag_x = dir_cos[15] ? 17'(-$signed({dir_cos[15], dir_cos})) : {1'b0, dir_cos};
		mag_y = ds_q[15] ? 17'(-$signed({ds_q[15], ds_q})) : {1'b0, ds_q};
	end

	// One shift-subtract step; dividend 2^26 brings in a single one bit first.
	always_comb begin
		div_trial   = {div_rem_q, (div_cnt_q == 5'd26)};
		div_sub     = 17'(div_trial - {1'b0, div_mag_q});
		div_qbit    = div_trial >= {1'b0, div_mag_q};
		div_quo_nxt = {div_quo_q[25:0], div_qbit};
	end

	// Saturate the full quotient, last bit included.
	always_comb begin
		if (div_mag_q == '0 || div_quo_nxt[26:18] != '0)
			div_res = ddarc_pkg::DIST_MAX;
		else
			div_res = div_quo_nxt[17:0];
	end

	// Multiplier operands by state.
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (state_q)
			ST_SIDEX: begin
				mul_a = dx_q;
				mul_b = dc_q[15] ? 18'(px_q[9:0]) : 18'(11'd1024 - 11'(px_q[9:0]));
			end
			ST_SIDEY: begin
				mul_a = dy_q;
				mul_b = ds_q[15] ? 18'(py_q[9:0]) : 18'(11'd1024 - 11'(py_q[9:0]));
			end
			ST_TEX1: begin
				mul_a = dist_q;
				mul_b = side_q ? 18'(dc_q) : 18'(ds_q);
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	logic [26:0] side_prod;
	assign side_prod = mul_q[36:10];

	assign wr_en = start && !busy && (op == ddarc_pkg::OP_WRITE) &&
		(32'(cell_x) < MAP_COLUMNS) && (32'(cell_y) < MAP_ROWS);

	always_ff @(posedge clk) begin
		if (wr_en)
			map_mem[AW'(cell_y) * AW'(MAP_COLUMNS) + AW'(cell_x)] <=
				{door_passable, tile_kind};
		map_rd_q <= map_mem[rd_addr_q];
	end

	logic [18:0] add_x, add_y;
	logic step_x;
	assign step_x = sidex_q < sidey_q;
	assign add_x  = {1'b0, sidex_q} + {1'b0, dx_q};
	assign add_y  = {1'b0, sidey_q} + {1'b0, dy_q};

	logic signed [MW-1:0] nmx, nmy;
	assign nmx = step_x ? mx_q + (dc_q[15] ? -MW'(1) : MW'(1)) : mx_q;
	assign nmy = step_x ? my_q : my_q + (ds_q[15] ? -MW'(1) : MW'(1));

	logic blocks, is_door;
	always_comb begin
		blocks  = 1'b0;
		is_door = 1'b0;
		if (oob_q)
			blocks = 1'b1;
		else if (map_rd_q[1:0] == ddarc_pkg::KIND_WALL)
			blocks = 1'b1;
		else if (map_rd_q[1:0] == ddarc_pkg::KIND_DOOR && !map_rd_q[2]) begin
			blocks  = 1'b1;
			is_door = 1'b1;
		end
	end

	logic [TW-1:0] tex_round;
	assign tex_round = texp_q[TW+25:26];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			max_cells_q <= ddarc_pkg::MAX_CELLS_RESET;
			done        <= 1'b0;
		end else begin
			done <= 1'b0;
			if (cfg_we)
				max_cells_q <= cfg_data;
			case (state_q)
				ST_IDLE: begin
					if (start && op == ddarc_pkg::OP_CAST)
						state_q <= ST_DIVX;
				end
				ST_DIVX: if (div_cnt_q == 5'd0) state_q <= ST_DIVY;
				ST_DIVY: if (div_cnt_q == 5'd0) state_q <= ST_SIDEX;
				ST_SIDEX: state_q <= ST_SIDEY;
				ST_SIDEY: state_q <= ST_SIDEW;
				ST_SIDEW: state_q <= ST_TEST;
				ST_TEST: begin
					if (hit_q || dist_q >= {max_cells_q, 12'd0})
						state_q <= ST_TEX1;
					else
						state_q <= ST_READ;
				end
				ST_READ:  state_q <= ST_CHECK;
				ST_CHECK: state_q <= ST_TEST;
				ST_TEX1:  state_q <= ST_TEX2;
				ST_TEX2:  state_q <= ST_TEX3;
				ST_TEX3: begin
					state_q <= ST_IDLE;
					done    <= 1'b1;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Datapath registers.
	always_ff @(posedge clk) begin
		mul_q <= $signed({1'b0, mul_a}) * mul_b;
		case (state_q)
			ST_IDLE: begin
				px_q      <= pos_x;
				py_q      <= pos_y;
				dc_q      <= dir_cos;
				ds_q      <= dir_sin;
				mx_q      <= MW'(pos_x[15:10]);
				my_q      <= MW'(pos_y[15:10]);
				dist_q    <= '0;
				side_q    <= 1'b0;
				hit_q     <= 1'b0;
				door_q    <= 1'b0;
				div_rem_q <= '0;
				div_quo_q <= '0;
				div_mag_q <= mag_x;
				div_cnt_q <= 5'd26;
			end
			ST_DIVX, ST_DIVY: begin
				if (div_cnt_q != 5'd0) begin
					// Advance one quotient bit.
					div_rem_q <= div_qbit ? div_sub : div_trial[16:0];
					div_quo_q <= div_quo_nxt;
					div_cnt_q <= div_cnt_q - 5'd1;
				end else if (state_q == ST_DIVX) begin
					dx_q      <= div_res;
					div_rem_q <= '0;
					div_quo_q <= '0;
					div_mag_q <= mag_y;
					div_cnt_q <= 5'd26;
				end else begin
					dy_q <= div_res;
				end
			end
			ST_SIDEX: ;
			ST_SIDEY: sidex_q <= (side_prod > 27'(ddarc_pkg::DIST_MAX)) ?
				ddarc_pkg::DIST_MAX : side_prod[17:0];
			ST_SIDEW: sidey_q <= (side_prod > 27'(ddarc_pkg::DIST_MAX)) ?
				ddarc_pkg::DIST_MAX : side_prod[17:0];
			ST_TEST: begin
				if (!(hit_q || dist_q >= {max_cells_q, 12'd0})) begin
					// Take one grid step and fetch the new cell.
					if (step_x) begin
						dist_q  <= sidex_q;
						sidex_q <= add_x[18] ? ddarc_pkg::DIST_MAX : add_x[17:0];
						side_q  <= 1'b0;
					end else begin
						dist_q  <= sidey_q;
						sidey_q <= add_y[18] ? ddarc_pkg::DIST_MAX : add_y[17:0];
						side_q  <= 1'b1;
					end
					mx_q      <= nmx;
					my_q      <= nmy;
					oob_q     <= nmx < 0 || nmx >= MW'(MAP_COLUMNS) ||
						nmy < 0 || nmy >= MW'(MAP_ROWS);
					rd_addr_q <= AW'(nmy[CYW-1:0]) * AW'(MAP_COLUMNS) + AW'(nmx[CXW-1:0]);
				end
			end
			ST_READ: ;
			ST_CHECK: begin
				hit_q  <= blocks;
				door_q <= is_door;
			end
			ST_TEX1: ;
			ST_TEX2: begin
				coord_q <= 43'($signed({1'b0, (side_q ? px_q : py_q), 16'd0})) +
					43'(mul_q);
			end
			ST_TEX3: ;
			default: ;
		endcase
		texp_q <= (TW+26)'(coord_q[25:0]) * (TW+26)'(TEX_COLUMNS) + (TW+26)'(1 << 25);
	end

	assign busy          = state_q != ST_IDLE;
	assign hit_distance  = dist_q;
	assign hit_side      = side_q;
	assign door_hit      = hit_q && door_q;
	assign limit_reached = !hit_q;
	assign tex_column    = (tex_round >= TW'(TEX_COLUMNS)) ? 6'(TEX_COLUMNS - 1) : 6'(tex_round);

	a_one_shot: assert property (@(posedge clk) disable iff (!arst_n) done |=> !done)
		else $error("done held");
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n) done |-> !busy)
		else $error("done while busy");

endmodule
